// ===== hw/rtl/eag_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exponential adaptive gain: shared package
// Widths, fixed-point constants, register defaults and the sideband types
// that travel with an item through the gain pipeline.
// ----------------------------------------------------------------------------
package eag_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 24;
	localparam int ADDR_W = 4;
	localparam int APB_W = 32;

	localparam int Q28 = 28;
	localparam int Q30 = 30;
	localparam logic [28:0] LOG2E_Q28 = 29'h17154765;
	localparam logic [29:0] LN2_Q30 = 30'h2C5C85FE;

	localparam int M_W = 2 * DATA_W;
	localparam int U_W = 34;
	localparam int U_LO = 17;
	localparam int UP_W = U_LO + 29;
	localparam int V_W = 34;
	localparam int K_W = V_W - Q28;
	localparam int T_W = Q28 + 1;
	localparam int Y_W = Q30;
	localparam int SUM_W = 32;
	localparam int SHIFT_W = 7;
	localparam int PROD_W = DATA_W + SUM_W;
	localparam int MAG_W = 50;
	localparam int G_W = MAG_W + 2;

	localparam int EXP_SHIFT = 2 * FRAC_BITS - Q28;
	localparam int EXP_SHR = (EXP_SHIFT > 0) ? EXP_SHIFT : 0;
	localparam int EXP_SHL = (EXP_SHIFT < 0) ? -EXP_SHIFT : 0;
	localparam logic [63:0] BOUND_GROW = 64'd17 << (2 * FRAC_BITS);
	localparam logic [63:0] BOUND_DECAY = 64'd40 << (2 * FRAC_BITS);

	localparam int TAYLOR_ORDER = 10;
	localparam int EXP_STAGES = 3;
	localparam int POW_STAGES = 2 * TAYLOR_ORDER;
	localparam int OUT_STAGES = 3;
	localparam int NUM_STAGES = EXP_STAGES + POW_STAGES + OUT_STAGES;

	localparam logic signed [DATA_W-1:0] GAIN_MAX = 24'sh7FFFFF;
	localparam logic signed [DATA_W-1:0] GAIN_MIN = -24'sh800000;

	localparam logic signed [DATA_W-1:0] SPAN_RESET = 24'sd98265;
	localparam logic signed [DATA_W-1:0] RATE_RESET = 24'sd72818;
	localparam logic signed [DATA_W-1:0] FLOOR_RESET = 24'sd10918;

	typedef enum logic [1:0] {
		OVR_NONE,
		OVR_FLOOR,
		OVR_HUGE
	} ovr_t;

	typedef struct packed {
		ovr_t ovr;
		logic [SHIFT_W-1:0] shift;
	} side_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gain_span;
		logic signed [DATA_W-1:0] decay_rate;
		logic signed [DATA_W-1:0] gain_floor;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/eag_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exponential adaptive gain: coefficient registers
// APB-style port holding the span, decay rate and floor coefficients.
// ----------------------------------------------------------------------------
module eag_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [eag_pkg::ADDR_W-1:0] paddr,
	input  logic [eag_pkg::APB_W-1:0]  pwdata,
	output logic [eag_pkg::APB_W-1:0]  prdata,
	output logic                        pready,
	output eag_pkg::cfg_t               cfg
);
	import eag_pkg::*;

	typedef enum logic [1:0] {
		REG_SPAN  = 2'd0,
		REG_RATE  = 2'd1,
		REG_FLOOR = 2'd2
	} reg_idx_t;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_span <= SPAN_RESET;
			cfg_q.decay_rate <= RATE_RESET;
			cfg_q.gain_floor <= FLOOR_RESET;
		end else if (wr_en) begin
			unique case (paddr[ADDR_W-1:2])
				REG_SPAN:  cfg_q.gain_span <= signed'(pwdata[DATA_W-1:0]);
				REG_RATE:  cfg_q.decay_rate <= signed'(pwdata[DATA_W-1:0]);
				REG_FLOOR: cfg_q.gain_floor <= signed'(pwdata[DATA_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			REG_SPAN:  prdata = APB_W'(cfg_q.gain_span);
			REG_RATE:  prdata = APB_W'(cfg_q.decay_rate);
			REG_FLOOR: prdata = APB_W'(cfg_q.gain_floor);
			default:   prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/eag_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exponential adaptive gain: pipeline control
// Valid bit per stage and per-stage load enables that close up bubbles.
// ----------------------------------------------------------------------------
module eag_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [eag_pkg::NUM_STAGES-1:0] en
);
	import eag_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;

	// A stage may load when the output drains or some stage at or after it is empty.
	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
		assign en[i] = m_tready | ~(&valid_q[NUM_STAGES-1:i]);
	end

	assign s_tready = en[0];
	assign m_tvalid = valid_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) valid_q[0] <= s_tvalid;
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) valid_q[i] <= valid_q[i-1];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/eag_expo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exponential adaptive gain: exponent front end
// Scales the error norm by the decay rate, converts to a base-2 exponent
// and splits it into the fraction for the power unit and the output shift.
// ----------------------------------------------------------------------------
module eag_expo (
	input  logic                            clk,
	input  logic [eag_pkg::EXP_STAGES-1:0] en,
	input  eag_pkg::cfg_t                   cfg,
	input  logic [eag_pkg::DATA_W-1:0]     x,
	output logic [eag_pkg::T_W-1:0]        t,
	output eag_pkg::side_t                  side
);
	import eag_pkg::*;

	logic [DATA_W-1:0] mb;
	logic [M_W-1:0]    m_s1;
	logic              grow_s1;

	logic [63:0]       bound;
	logic [U_W-1:0]    u;
	ovr_t              ovr;
	logic [UP_W-1:0]   plo_s2;
	logic [UP_W-1:0]   phi_s2;
	logic              grow_s2;
	ovr_t              ovr_s2;

	logic [63:0]        vsum;
	logic [V_W-1:0]     v;
	logic [K_W-1:0]     k;
	logic [Q28-1:0]     f;
	logic [SHIFT_W-1:0] kk;
	logic [T_W-1:0]     t_nx;
	logic [SHIFT_W-1:0] s_nx;
	logic [T_W-1:0]     t_s3;
	side_t              side_s3;

	assign mb = cfg.decay_rate[DATA_W-1] ? unsigned'(-cfg.decay_rate)
		: unsigned'(cfg.decay_rate);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			m_s1 <= M_W'(mb) * M_W'(x);
			grow_s1 <= cfg.decay_rate[DATA_W-1];
		end
	end

	always_comb begin
		bound = grow_s1 ? BOUND_GROW : BOUND_DECAY;
		u = U_W'((64'(m_s1) >> EXP_SHR) << EXP_SHL);
		if (cfg.gain_span == '0) begin
			ovr = OVR_FLOOR;
		end else if (64'(m_s1) >= bound) begin
			ovr = grow_s1 ? OVR_HUGE : OVR_FLOOR;
		end else begin
			ovr = OVR_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			plo_s2 <= UP_W'(u[U_LO-1:0]) * UP_W'(LOG2E_Q28);
			phi_s2 <= UP_W'(u[U_W-1:U_LO]) * UP_W'(LOG2E_Q28);
			grow_s2 <= grow_s1;
			ovr_s2 <= ovr;
		end
	end

	always_comb begin
		vsum = (64'(phi_s2) << U_LO) + 64'(plo_s2) + (64'd1 << (Q28 - 1));
		v = vsum[Q28 +: V_W];
		k = v[V_W-1:Q28];
		f = v[Q28-1:0];
		if (grow_s2) begin
			t_nx = T_W'(f);
			kk = SHIFT_W'(k);
			s_nx = (k < K_W'(Q30)) ? SHIFT_W'(Q30) - SHIFT_W'(k) : SHIFT_W'(1);
		end else begin
			if (f != '0) begin
				t_nx = (T_W'(1) << Q28) - T_W'(f);
				kk = SHIFT_W'(k) + SHIFT_W'(1);
			end else begin
				t_nx = '0;
				kk = SHIFT_W'(k);
			end
			s_nx = (kk < SHIFT_W'(40)) ? SHIFT_W'(Q30) + kk : SHIFT_W'(70);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s3 <= t_nx;
			side_s3.ovr <= ovr_s2;
			side_s3.shift <= s_nx;
		end
	end

	assign t = t_s3;
	assign side = side_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/eag_pow2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exponential adaptive gain: fractional power of two
// Evaluates 2^t as a degree-ten Taylor series of exp(t*ln2) in Q30, at most
// one multiply per stage, with each term divided by its index through a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module eag_pow2 (
	input  logic                            clk,
	input  logic [eag_pkg::POW_STAGES-1:0] en,
	input  logic [eag_pkg::T_W-1:0]        t,
	input  eag_pkg::side_t                  side_in,
	output logic [eag_pkg::SUM_W-1:0]      sum,
	output eag_pkg::side_t                  side_out
);
	import eag_pkg::*;

	localparam int LAST = POW_STAGES - 1;

	logic [T_W+Y_W-1:0] yprod;
	logic [Y_W-1:0]     y0;
	logic [Y_W-1:0]     y_s    [0:LAST-1];
	logic [Y_W-1:0]     term_s [0:LAST-1];
	logic [SUM_W-1:0]   sum_s  [0:LAST];
	side_t              side_s [0:LAST];

	assign yprod = (T_W+Y_W)'(t) * (T_W+Y_W)'(LN2_Q30) + ((T_W+Y_W)'(1) << (Q28 - 1));
	assign y0 = yprod[Q28 +: Y_W];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			y_s[0] <= y0;
			term_s[0] <= y0;
			sum_s[0] <= SUM_W'(1) << Q30;
			side_s[0] <= side_in;
		end
	end

	for (genvar j = 0; j < TAYLOR_ORDER - 1; j++) begin : g_term
		localparam int IA = 1 + 2 * j;
		localparam int IB = 2 + 2 * j;
		localparam int N = j + 2;
		localparam int L = $clog2(N);
		localparam logic [31:0] RECIP = 32'(((64'd1 << (Q30 + L)) + 64'(N) - 64'd1) / 64'(N));

		logic [2*Y_W-1:0]  mul_a;
		logic [Y_W+31:0]   mul_b;

		assign mul_a = (2*Y_W)'(term_s[IA-1]) * (2*Y_W)'(y_s[IA-1]);
		assign mul_b = (Y_W+32)'(term_s[IA]) * (Y_W+32)'(RECIP);

		always_ff @(posedge clk) begin
			if (en[IA]) begin
				term_s[IA] <= mul_a[Q30 +: Y_W];
				y_s[IA] <= y_s[IA-1];
				sum_s[IA] <= sum_s[IA-1] + SUM_W'(term_s[IA-1]);
				side_s[IA] <= side_s[IA-1];
			end
			if (en[IB]) begin
				term_s[IB] <= Y_W'(mul_b >> (Q30 + L));
				y_s[IB] <= y_s[IB-1];
				sum_s[IB] <= sum_s[IB-1];
				side_s[IB] <= side_s[IB-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[LAST]) begin
			sum_s[LAST] <= sum_s[LAST-1] + SUM_W'(term_s[LAST-1]);
			side_s[LAST] <= side_s[LAST-1];
		end
	end

	assign sum = sum_s[LAST];
	assign side_out = side_s[LAST];

endmodule
`default_nettype wire

// ===== hw/rtl/eag_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exponential adaptive gain: output stage
// Scales the power of two by the span, rounds, adds the floor and
// saturates the gain to the output range.
// ----------------------------------------------------------------------------
module eag_out (
	input  logic                            clk,
	input  logic [eag_pkg::OUT_STAGES-1:0] en,
	input  eag_pkg::cfg_t                   cfg,
	input  logic [eag_pkg::SUM_W-1:0]      sum,
	input  eag_pkg::side_t                  side,
	output logic signed [eag_pkg::DATA_W-1:0] gain,
	output logic                            saturated
);
	import eag_pkg::*;

	logic [DATA_W-1:0]   ma;
	logic [PROD_W-1:0]   prod_s1;
	side_t               side_s1;

	logic [PROD_W:0]     rnd;
	logic [MAG_W-1:0]    mag;
	logic [MAG_W-1:0]    mag_s2;
	ovr_t                ovr_s2;

	logic                a_neg;
	logic signed [G_W-1:0] mag_sx;
	logic signed [G_W-1:0] g;
	logic signed [DATA_W-1:0] gain_nx;
	logic                sat_nx;
	logic signed [DATA_W-1:0] gain_s3;
	logic                sat_s3;

	assign a_neg = cfg.gain_span[DATA_W-1];
	assign ma = a_neg ? unsigned'(-cfg.gain_span) : unsigned'(cfg.gain_span);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= PROD_W'(ma) * PROD_W'(sum);
			side_s1 <= side;
		end
	end

	// The product is below 2^PROD_W, so any larger shift rounds to zero.
	always_comb begin
		rnd = (PROD_W+1)'(prod_s1) + ((PROD_W+1)'(1) << (side_s1.shift - SHIFT_W'(1)));
		if (side_s1.shift > SHIFT_W'(PROD_W)) begin
			mag = '0;
		end else begin
			mag = MAG_W'(rnd >> side_s1.shift);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mag_s2 <= mag;
			ovr_s2 <= side_s1.ovr;
		end
	end

	always_comb begin
		mag_sx = signed'(G_W'(mag_s2));
		case (ovr_s2)
			OVR_FLOOR: g = G_W'(cfg.gain_floor);
			OVR_HUGE:  g = a_neg ? G_W'(GAIN_MIN) - G_W'(1) : G_W'(GAIN_MAX) + G_W'(1);
			default:   g = (a_neg ? -mag_sx : mag_sx) + G_W'(cfg.gain_floor);
		endcase
		if (g > G_W'(GAIN_MAX)) begin
			gain_nx = GAIN_MAX;
			sat_nx = 1'b1;
		end else if (g < G_W'(GAIN_MIN)) begin
			gain_nx = GAIN_MIN;
			sat_nx = 1'b1;
		end else begin
			gain_nx = DATA_W'(g);
			sat_nx = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			gain_s3 <= gain_nx;
			sat_s3 <= sat_nx;
		end
	end

	assign gain = gain_s3;
	assign saturated = sat_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/exponential_adaptive_gain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exponential adaptive gain
// Returns gain = span * exp(-rate * error_norm) + floor in signed Q8.16.
// Throughput is one item per cycle unless the output stalls; the pipeline
// depth is set by the ten Taylor terms of the power-of-two unit, two
// multiply stages per term.
// Reset empties the pipeline and loads the default coefficients.
// ----------------------------------------------------------------------------
module exponential_adaptive_gain (
	input  logic                        clk,
	input  logic                        arst_n,
	// error_norm [23:0]
	input  logic [23:0]                 s_tdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// gain [23:0]
	output logic [23:0]                 m_tdata,
	// saturated [0]
	output logic [0:0]                  m_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [eag_pkg::ADDR_W-1:0] paddr,
	input  logic [eag_pkg::APB_W-1:0]  pwdata,
	output logic [eag_pkg::APB_W-1:0]  prdata,
	output logic                        pready
);
	import eag_pkg::*;

	cfg_t                     cfg;
	logic [NUM_STAGES-1:0]    en;
	logic [T_W-1:0]           t;
	side_t                    side_exp;
	logic [SUM_W-1:0]         pow_sum;
	side_t                    side_pow;
	logic signed [DATA_W-1:0] gain;
	logic                     saturated;

	eag_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	eag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.en       (en)
	);

	eag_expo u_expo (
		.clk  (clk),
		.en   (en[EXP_STAGES-1:0]),
		.cfg  (cfg),
		.x    (s_tdata),
		.t    (t),
		.side (side_exp)
	);

	eag_pow2 u_pow2 (
		.clk      (clk),
		.en       (en[EXP_STAGES +: POW_STAGES]),
		.t        (t),
		.side_in  (side_exp),
		.sum      (pow_sum),
		.side_out (side_pow)
	);

	eag_out u_out (
		.clk       (clk),
		.en        (en[NUM_STAGES-1 -: OUT_STAGES]),
		.cfg       (cfg),
		.sum       (pow_sum),
		.side      (side_pow),
		.gain      (gain),
		.saturated (saturated)
	);

	assign m_tdata = unsigned'(gain);
	assign m_tuser = saturated;

endmodule
`default_nettype wire

// ===== tb/eag_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential adaptive gain testbench: shared definitions
// Register indexes of the coefficient port, used by the stimulus and by the
// checker that decodes the same writes.
// ----------------------------------------------------------------------------
package eag_tb_pkg;

	typedef enum logic [1:0] {
		REG_GAIN_SPAN,
		REG_DECAY_RATE,
		REG_GAIN_FLOOR,
		REG_UNUSED
	} coef_reg_t;

endpackage

// ===== tb/gain_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential adaptive gain: result checker
// Tracks the coefficient writes on the register port, computes the expected
// gain and saturation flag of every accepted error norm in bit-exact fixed
// point, and compares each delivered result against the oldest expectation.
// ----------------------------------------------------------------------------
module gain_checker
	import eag_pkg::*, eag_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [23:0]       s_tdata,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [23:0]       m_tdata,
	input  logic [0:0]        m_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output int                checked,
	output int                sat_seen
);

	localparam bit [63:0] LOG2E_FACTOR = 64'h17154765;
	localparam bit [63:0] LN2_FACTOR = 64'h2C5C85FE;
	localparam bit [63:0] UNIT_Q28 = 64'd1 << 28;
	localparam bit [63:0] UNIT_Q30 = 64'd1 << 30;
	localparam longint LIMIT_HI = 8388607;
	localparam longint LIMIT_LO = -8388608;

	typedef struct packed {
		logic [23:0] norm;
		logic [23:0] gain;
		logic        saturated;
	} gain_expect_t;

	logic signed [23:0] span_q = SPAN_RESET;
	logic signed [23:0] rate_q = RATE_RESET;
	logic signed [23:0] floor_q = FLOOR_RESET;
	gain_expect_t expected_gains[$];
	gain_expect_t want;

	function automatic bit [63:0] pow2_q30(input bit [63:0] t);
		bit [63:0] y, sum, term;
		y = (t * LN2_FACTOR + (64'd1 << 27)) >> 28;
		sum = UNIT_Q30;
		term = UNIT_Q30;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * y) >> 30) / n;
			sum += term;
		end
		return sum;
	endfunction

	function automatic gain_expect_t predict_gain(input logic [23:0] norm);
		longint a, b, c, g;
		bit [63:0] mb, m, bound, u, v, k, f, ma, prod, mag, t, kk;
		int unsigned s;
		bit grow;
		gain_expect_t r;
		a = span_q;
		b = rate_q;
		c = floor_q;
		r.norm = norm;
		r.saturated = 1'b0;
		if (a == 0) begin
			g = c;
		end else begin
			grow = (b < 0);
			if (grow) mb = -b;
			else mb = b;
			m = mb * 64'(norm);
			bound = (grow ? 64'd17 : 64'd40) << (2 * FRAC_BITS);
			if (m >= bound) begin
				if (grow) g = (a > 0) ? LIMIT_HI + 1 : LIMIT_LO - 1;
				else g = c;
			end else begin
				u = m >> (2 * FRAC_BITS - Q28);
				v = (u * LOG2E_FACTOR + (64'd1 << 27)) >> 28;
				k = v >> 28;
				f = v & (UNIT_Q28 - 1);
				if (a < 0) ma = -a;
				else ma = a;
				if (grow) begin
					prod = ma * pow2_q30(f);
					s = (k < 30) ? 30 - k : 1;
				end else begin
					t = 0;
					kk = k;
					if (f != 0) begin
						t = UNIT_Q28 - f;
						kk = k + 1;
					end
					prod = ma * pow2_q30(t);
					s = (kk < 40) ? 30 + kk : 70;
				end
				if (s >= 63) mag = 0;
				else mag = (prod + (64'd1 << (s - 1))) >> s;
				g = ((a < 0) ? -longint'(mag) : longint'(mag)) + c;
			end
		end
		if (g > LIMIT_HI) begin
			g = LIMIT_HI;
			r.saturated = 1'b1;
		end else if (g < LIMIT_LO) begin
			g = LIMIT_LO;
			r.saturated = 1'b1;
		end
		r.gain = g[23:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q = SPAN_RESET;
			rate_q = RATE_RESET;
			floor_q = FLOOR_RESET;
			expected_gains.delete();
			fail_count = 0;
			checked = 0;
			sat_seen = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (coef_reg_t'(paddr[ADDR_W-1:2]))
					REG_GAIN_SPAN: span_q = pwdata[23:0];
					REG_DECAY_RATE: rate_q = pwdata[23:0];
					REG_GAIN_FLOOR: floor_q = pwdata[23:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_gains.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected gain %h sat %b at %0t", m_tdata, m_tuser[0], $time);
					fail_count++;
				end else begin
					want = expected_gains.pop_front();
					checked++;
					if (m_tuser[0]) sat_seen++;
					if (m_tdata !== want.gain || m_tuser[0] !== want.saturated) begin
						if (fail_count < 10)
							$display("Norm %h: expected gain %h sat %b, got gain %h sat %b",
								want.norm, want.gain, want.saturated, m_tdata, m_tuser[0]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) expected_gains.push_back(predict_gain(s_tdata));
			pending <= expected_gains.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponential adaptive gain: testbench top
// Drives error norms in bursts under a set of coefficient settings written
// through the register port, with random backpressure on the result side.
// A directed part covers the field extremes and the boundary cases; the
// random part mostly aims the norms into the active range of the curve.
// ----------------------------------------------------------------------------
module tb_top;
	import eag_pkg::*;
	import eag_tb_pkg::*;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_HALF,
		READY_MOSTLY,
		READY_RARE
	} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [23:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0] pwdata = '0;
	logic [APB_W-1:0] prdata;
	logic pready;

	int fail_count, pending, checked, sat_seen;
	int burst_left = 0;
	int norms_sent = 0;
	int settings = 1;
	logic signed [23:0] cur_rate = RATE_RESET;
	ready_mode_t ready_mode = READY_ALWAYS;
	int ready_left = 0;

	exponential_adaptive_gain DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gain_checker gain_check (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending), .checked(checked), .sat_seen(sat_seen)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_left = $urandom_range(8, 120);
		end else begin
			ready_left--;
		end
		case (ready_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_HALF: m_tready <= ($urandom_range(0, 1) == 1);
			READY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic int burst_len();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
	endfunction

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) return $urandom_range(1, 3);
		if (pick < 9) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [23:0] pick_coef();
		int unsigned w;
		logic [23:0] v;
		case ($urandom_range(0, 7))
			0: v = 24'h7FFFFF;
			1: v = 24'h800000;
			2: v = '0;
			3: v = 24'($urandom);
			default: begin
				w = $urandom_range(1, 23);
				v = 24'($urandom & ((32'd1 << w) - 1));
				if ($urandom_range(0, 1) == 1) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [23:0] pick_norm();
		longint rate;
		bit [63:0] reach;
		int unsigned w;
		rate = cur_rate;
		if (rate != 0 && $urandom_range(0, 9) < 6) begin
			reach = ((rate < 0 ? 64'd17 : 64'd40) << (2 * FRAC_BITS)) /
				64'(rate < 0 ? -rate : rate);
			if (reach > 64'hFFFFFF) reach = 64'hFFFFFF;
			return 24'($urandom_range(0, 32'(reach)));
		end
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom);
			default: begin
				w = $urandom_range(1, 24);
				return 24'($urandom & ((32'd1 << w) - 1));
			end
		endcase
	endfunction

	task automatic reg_write(input coef_reg_t idx, input logic [23:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= {8'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_coefs(input logic [23:0] span, input logic [23:0] rate,
		input logic [23:0] floor_val, input bit spare);
		reg_write(REG_GAIN_SPAN, span);
		reg_write(REG_DECAY_RATE, rate);
		if (spare) reg_write(REG_UNUSED, 24'($urandom));
		reg_write(REG_GAIN_FLOOR, floor_val);
		cur_rate = rate;
		settings++;
	endtask

	task automatic push_norm(input logic [23:0] norm);
		s_tdata <= norm;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		norms_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
			burst_left = burst_len();
		end
	endtask

	task automatic wait_for_gains();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		burst_left = burst_len();
	endtask

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = burst_len();

		push_norm(24'h000000);
		push_norm(24'h000001);
		push_norm(24'h010000);
		push_norm(24'h7FFFFF);
		push_norm(24'h800000);
		push_norm(24'hFFFFFF);
		wait_for_gains();

		load_coefs(24'h000000, 24'h010000, pick_coef(), 1'b1);
		push_norm(24'h000000);
		push_norm(24'hFFFFFF);
		wait_for_gains();

		load_coefs(24'h7FFFFF, 24'h000000, 24'h7FFFFF, 1'b0);
		push_norm(24'h000000);
		push_norm(24'hFFFFFF);
		wait_for_gains();

		load_coefs(24'h800000, 24'h800000, 24'h800000, 1'b0);
		push_norm(24'h000000);
		push_norm(24'h000001);
		push_norm(24'h000800);
		push_norm(24'h010000);
		wait_for_gains();

		load_coefs(24'h7FFFFF, 24'h7FFFFF, 24'h000000, 1'b0);
		push_norm(24'd20479);
		push_norm(24'd20480);
		push_norm(24'd20481);
		push_norm(24'hFFFFFF);
		wait_for_gains();

		load_coefs(24'h000001, 24'hFF0000, 24'h000000, 1'b0);
		push_norm(24'h10FFFF);
		push_norm(24'h110000);
		push_norm(24'h080000);
		wait_for_gains();

		for (int p = 0; p < 16; p++) begin
			if (p == 0) load_coefs(SPAN_RESET, RATE_RESET, FLOOR_RESET, 1'b0);
			else load_coefs(pick_coef(), pick_coef(), pick_coef(), $urandom_range(0, 3) == 0);
			repeat (100) push_norm(pick_norm());
			wait_for_gains();
		end

		repeat (40) @(posedge clk);
		$display("Sent %0d error norms under %0d coefficient settings.", norms_sent, settings);
		$display("Compared %0d gains, %0d of them saturated.", checked, sat_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
